@@ hdl/tmas_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the trajectory smoother.
// No dependencies; used by the controller, the datapath and the top level.
package tmas_pkg;

	localparam int ChW   = 32;
	localparam int AccW  = 48;
	localparam int SumW  = 56;
	localparam int SlotW = 7;
	localparam int FsW   = 8;
	localparam int RadW  = 6;
	localparam int NumCh = 3;
	localparam int DepthS = 128;
	localparam int DivCntW = 6;

	localparam logic [RadW-1:0]    RadiusRst = 6'd50;
	localparam logic [SlotW-1:0]   ResultCap = 7'd64;
	localparam logic [SlotW-1:0]   PendMax   = 7'd127;
	localparam logic [FsW-1:0]     FsMax     = 8'd128;
	localparam logic [DivCntW-1:0] DivLast   = 6'(SumW - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_TRIM,
		ST_TRIM_SUB,
		ST_EM_CHECK,
		ST_EM_DROP,
		ST_EM_DROP_SUB,
		ST_EM_DIV,
		ST_EM_OUT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;
		logic acc_upd;
		logic rd_oldest;
		logic sub_oldest;
		logic rd_prev;
		logic div_start;
		logic out_load;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic trim_need;
		logic emit_need;
		logic drop_need;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

@@ hdl/tmas_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the trajectory smoother: accumulate, trim, emit loop, finish.
// Depends on tmas_pkg; drives the datapath through cmd_t.
module tmas_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  tmas_pkg::sts_t sts,
	output tmas_pkg::cmd_t cmd
);
	import tmas_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.load_in = 1'b1;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_upd = 1'b1;
				state_d = ST_TRIM;
			end
			ST_TRIM: begin
				if (sts.trim_need) begin
					cmd.rd_oldest = 1'b1;
					state_d = ST_TRIM_SUB;
				end else
					state_d = ST_EM_CHECK;
			end
			ST_TRIM_SUB: begin
				cmd.sub_oldest = 1'b1;
				state_d = ST_TRIM;
			end
			ST_EM_CHECK: begin
				state_d = sts.emit_need ? ST_EM_DROP : ST_FINISH;
			end
			ST_EM_DROP: begin
				if (sts.drop_need) begin
					cmd.rd_oldest = 1'b1;
					state_d = ST_EM_DROP_SUB;
				end else begin
					// fetch the previous trajectory value and start the divide
					cmd.rd_prev = 1'b1;
					cmd.div_start = 1'b1;
					state_d = ST_EM_DIV;
				end
			end
			ST_EM_DROP_SUB: begin
				cmd.sub_oldest = 1'b1;
				state_d = ST_EM_DROP;
			end
			ST_EM_DIV: begin
				if (sts.div_done)
					state_d = ST_EM_OUT;
			end
			ST_EM_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_EM_CHECK;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ hdl/tmas_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the trajectory smoother: accumulators, trajectory rings, window
// sums, bit-serial dividers and the output register. Depends on tmas_pkg.
module tmas_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [tmas_pkg::RadW-1:0]  cfg_wr_data,
	input  logic [3*tmas_pkg::ChW-1:0] s_axis_tdata,
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [3*tmas_pkg::ChW-1:0] m_axis_tdata,
	output logic                       m_axis_tlast,
	input  tmas_pkg::cmd_t             cmd,
	output tmas_pkg::sts_t             sts
);
	import tmas_pkg::*;

	logic [3*ChW-1:0]  in_q;
	logic              last_q;
	logic [RadW-1:0]   radius_q;
	logic [SlotW-1:0]  ws_q;
	logic [FsW-1:0]    fs_q;
	logic [SlotW-1:0]  pend_q;
	logic [SlotW-1:0]  n_q;
	logic              div_busy_q;
	logic [DivCntW-1:0] div_cnt_q;
	logic              clr;
	logic              rd_en;
	logic [SlotW-1:0]  rd_addr;
	logic              k_zero;
	logic              prev_zero;
	logic [ChW-1:0]    res [NumCh];
	logic              m_tvalid_q;
	logic [3*ChW-1:0]  m_tdata_q;
	logic              m_tlast_q;

	assign clr = cmd.finish && last_q;
	assign rd_en = cmd.rd_oldest || cmd.rd_prev;
	// oldest in window is fs back from the write slot; previous frame is pend+1 back
	assign rd_addr = cmd.rd_oldest ? (ws_q - fs_q[SlotW-1:0]) : (ws_q - 7'd1 - pend_q);
	assign k_zero = (pend_q == 7'd1);
	assign prev_zero = ({1'b0, pend_q} >= fs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadiusRst;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= s_axis_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			ws_q   <= '0;
			fs_q   <= '0;
			pend_q <= '0;
			n_q    <= '0;
		end else if (clr) begin
			ws_q   <= '0;
			fs_q   <= '0;
			pend_q <= '0;
		end else begin
			if (cmd.load_in) begin
				last_q <= s_axis_tlast;
				n_q    <= '0;
			end
			if (cmd.acc_upd) begin
				ws_q <= ws_q + 7'd1;
				if (fs_q < FsMax)
					fs_q <= fs_q + 8'd1;
				if (pend_q < PendMax)
					pend_q <= pend_q + 7'd1;
			end
			if (cmd.sub_oldest)
				fs_q <= fs_q - 8'd1;
			if (cmd.out_load) begin
				pend_q <= pend_q - 7'd1;
				n_q    <= n_q + 7'd1;
			end
		end
	end

	// shared step counter of the three dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + 6'd1;
			if (div_cnt_q == DivLast)
				div_busy_q <= 1'b0;
		end
	end

	for (genvar g = 0; g < NumCh; g++) begin : g_ch
		logic signed [AccW-1:0] mem [DepthS];
		logic signed [AccW-1:0] rdata_q;
		logic signed [AccW-1:0] acc_q;
		logic signed [AccW-1:0] acc_old_q;
		logic signed [SumW-1:0] sum_q;
		logic signed [ChW-1:0]  din;
		logic signed [AccW:0]   acc_wide;
		logic signed [AccW-1:0] acc_new;
		logic [SumW-1:0]        dq_q;
		logic [7:0]             rem_q;
		logic                   neg_q;
		logic [8:0]             rem_sh;
		logic                   ge;
		logic signed [SumW-1:0] avg;
		logic signed [AccW-1:0] prev;
		logic signed [SumW:0]   diff;

		assign din = in_q[g*ChW +: ChW];
		assign acc_wide = {acc_q[AccW-1], acc_q} + (AccW+1)'(din);

		always_comb begin
			if (acc_wide[AccW] != acc_wide[AccW-1])
				acc_new = acc_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
			else
				acc_new = acc_wide[AccW-1:0];
		end

		always_ff @(posedge clk) begin
			if (cmd.acc_upd)
				mem[ws_q] <= acc_new;
			if (rd_en)
				rdata_q <= mem[rd_addr];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q     <= '0;
				acc_old_q <= '0;
				sum_q     <= '0;
			end else if (clr) begin
				acc_q <= '0;
				sum_q <= '0;
			end else if (cmd.acc_upd) begin
				acc_old_q <= acc_q;
				acc_q     <= acc_new;
				sum_q     <= sum_q + SumW'(acc_new);
			end else if (cmd.sub_oldest) begin
				sum_q <= sum_q - SumW'(rdata_q);
			end
		end

		// restoring divide of |sum| by frames_seen, one quotient bit per cycle
		assign rem_sh = {rem_q, dq_q[SumW-1]};
		assign ge = (rem_sh >= {1'b0, fs_q});

		always_ff @(posedge clk) begin
			if (cmd.div_start) begin
				dq_q  <= sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
				neg_q <= sum_q[SumW-1];
				rem_q <= '0;
			end else if (div_busy_q) begin
				rem_q <= ge ? 8'(rem_sh - {1'b0, fs_q}) : rem_sh[7:0];
				dq_q  <= {dq_q[SumW-2:0], ge};
			end
		end

		assign avg  = neg_q ? -$signed(dq_q) : $signed(dq_q);
		assign prev = k_zero ? acc_old_q : (prev_zero ? '0 : rdata_q);
		assign diff = (SumW+1)'(avg) - (SumW+1)'(prev);

		always_comb begin
			if (diff > (SumW+1)'($signed(32'h7fffffff)))
				res[g] = 32'h7fffffff;
			else if (diff < (SumW+1)'($signed(32'h80000000)))
				res[g] = 32'h80000000;
			else
				res[g] = diff[ChW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_axis_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {res[2], res[1], res[0]};
			m_tlast_q <= last_q && k_zero;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tlast  = m_tlast_q;

	assign sts.trim_need = (fs_q > {1'b0, radius_q, 1'b1});
	assign sts.emit_need = (n_q < ResultCap) &&
		((pend_q > {1'b0, radius_q}) || (last_q && (pend_q != '0)));
	assign sts.drop_need = ({1'b0, fs_q} > (9'(pend_q) + 9'(radius_q)));
	assign sts.div_done  = !div_busy_q;
	assign sts.out_free  = !m_tvalid_q || m_axis_tready;

endmodule

@@ hdl/trajectory_moving_average_smoother.sv @@
`timescale 1ns / 1ps
// Centered moving-average trajectory smoother, one motion word per frame.
// A word's first result waits on the trim of any window entries beyond the
// radius; each result waits on the drop of entries outside its own window, a
// 56-step serial divide and any output stall. The next word is taken only once
// the last result of a word loads, or once a word with no result is done.
// Reset: async active low clears accumulators, window and counters; radius 50.
module trajectory_moving_average_smoother (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,   // radius
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // in_dx, in_dy, in_da
	input  logic        s_axis_tlast,  // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // out_dx, out_dy, out_da
	output logic        m_axis_tlast   // out_last
);
	import tmas_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tmas_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.sts          (sts),
		.cmd          (cmd)
	);

	tmas_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cmd          (cmd),
		.sts          (sts)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken word");

	a_accept_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> cmd.acc_upd)
		else $error("accepted word did not update the trajectory");

	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_oldest && cmd.rd_prev))
		else $error("two ring reads in one cycle");

endmodule

@@ dv/trajectory_moving_average_smoother_checker.sv @@
`timescale 1ns / 1ps
// Checker for the trajectory smoother: watches the config port and both streams,
// predicts the smoothed motion of each frame and compares every result word.
// Depends on tmas_pkg for widths.
module trajectory_moving_average_smoother_checker
	import tmas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          results_owed
);

	localparam longint TrajMax = (longint'(1) <<< 47) - 1;
	localparam longint TrajMin = -TrajMax - 1;

	typedef struct {
		logic [95:0] motion;
		logic        last;
	} smoothed_t;

	smoothed_t   smoothed_q[$];
	logic [RadW-1:0] radius_m;
	longint      traj_ring[NumCh][DepthS];
	longint      traj_acc[NumCh];
	longint      win_sum[NumCh];
	logic [6:0]  next_slot;
	int unsigned in_window;
	int unsigned unemitted;

	function automatic longint clamp64(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// slot of the entry d frames older than the newest
	function automatic logic [6:0] slot_back(int unsigned d);
		return next_slot - 7'd1 - 7'(d);
	endfunction

	task automatic drop_oldest();
		logic [6:0] s;
		s = slot_back(in_window - 1);
		for (int ch = 0; ch < NumCh; ch++) win_sum[ch] -= traj_ring[ch][s];
		in_window--;
	endtask

	task automatic emit_frame(int unsigned k, int unsigned r, longint acc_old[NumCh], bit last);
		smoothed_t e;
		longint avg, prev, v;
		while (in_window > k + r + 1) drop_oldest();
		for (int ch = 0; ch < NumCh; ch++) begin
			avg = in_window != 0 ? win_sum[ch] / longint'(in_window) : 0;
			if (k == 0) prev = acc_old[ch];
			else if (k + 1 >= in_window) prev = 0;
			else prev = traj_ring[ch][slot_back(k + 1)];
			v = clamp64(avg - prev, -64'sd2147483648, 64'sd2147483647);
			e.motion[ch*ChW +: ChW] = v[31:0];
		end
		e.last = last;
		smoothed_q.push_back(e);
	endtask

	task automatic smooth_frame(logic [95:0] d, logic last);
		int unsigned r, n;
		longint acc_old[NumCh];
		r = radius_m;
		n = 0;
		for (int ch = 0; ch < NumCh; ch++) begin
			acc_old[ch] = traj_acc[ch];
			traj_acc[ch] = clamp64(traj_acc[ch] + longint'($signed(d[ch*ChW +: ChW])),
				TrajMin, TrajMax);
			traj_ring[ch][next_slot] = traj_acc[ch];
			win_sum[ch] += traj_acc[ch];
		end
		next_slot++;
		if (in_window < DepthS) in_window++;
		while (in_window > 2 * r + 1) drop_oldest();
		if (unemitted < 127) unemitted++;
		while (unemitted > r && n < 64) begin
			emit_frame(unemitted - 1, r, acc_old, last && unemitted == 1);
			n++;
			unemitted--;
		end
		if (last) begin
			while (unemitted > 0 && n < 64) begin
				emit_frame(unemitted - 1, r, acc_old, unemitted == 1);
				n++;
				unemitted--;
			end
			for (int ch = 0; ch < NumCh; ch++) begin
				traj_acc[ch] = 0;
				win_sum[ch] = 0;
			end
			next_slot = 0;
			in_window = 0;
			unemitted = 0;
		end
	endtask

	task automatic check_word();
		smoothed_t e;
		if (smoothed_q.size() == 0) begin
			$display("%0t: unexpected word dx %h dy %h da %h last %b", $time,
				m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tlast);
			fail_count++;
			return;
		end
		e = smoothed_q.pop_front();
		for (int ch = 0; ch < NumCh; ch++)
			if (m_axis_tdata[ch*ChW +: ChW] !== e.motion[ch*ChW +: ChW]) begin
				$display("%0t: channel %0d expected %h actual %h", $time, ch,
					e.motion[ch*ChW +: ChW], m_axis_tdata[ch*ChW +: ChW]);
				fail_count++;
			end
		if (m_axis_tlast !== e.last) begin
			$display("%0t: last expected %b actual %b", $time, e.last, m_axis_tlast);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		results_owed = 0;
		radius_m = RadiusRst;
		for (int ch = 0; ch < NumCh; ch++) begin
			traj_acc[ch] = 0;
			win_sum[ch] = 0;
		end
		next_slot = 0;
		in_window = 0;
		unemitted = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) radius_m <= cfg_wr_data;
			// predict first: a word may be accepted on the same edge as an earlier result is taken
			if (s_axis_tvalid && s_axis_tready) smooth_frame(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) check_word();
			results_owed = smoothed_q.size();
		end
	end

endmodule

@@ dv/trajectory_moving_average_smoother_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the trajectory smoother: clock, reset, stimulus and verdict.
// Depends on tmas_pkg, the block and trajectory_moving_average_smoother_checker.
module trajectory_moving_average_smoother_test;
	import tmas_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [5:0]  cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	int          results_owed;
	int          words_sent = 0;
	int          words_taken = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	trajectory_moving_average_smoother DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	trajectory_moving_average_smoother_checker smoothing_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count), .results_owed(results_owed)
	);

	// mostly short gaps, some zero runs, a few long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	function automatic logic [31:0] pick_motion();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic send_frame(logic [31:0] dx, logic [31:0] dy, logic [31:0] da, logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {da, dy, dx};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
		@(negedge clk);
	endtask

	// write only once the block is idle again
	task automatic set_radius(logic [5:0] r);
		s_axis_tvalid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_sequence(int len);
		for (int i = 0; i < len; i++)
			send_frame(pick_motion(), pick_motion(), pick_motion(), i == len - 1);
	endtask

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (words_taken == 20 && words_sent > 0) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				words_taken++;
			end
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			words_taken++;
		end
	end

	initial begin
		logic [5:0] radius_list[8];
		int r, len;
		radius_list = '{6'd0, 6'd63, 6'd1, 6'd3, 6'd50, 6'd7, 6'd2, 6'd12};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: radius 0, extremes and a lone last frame
		set_radius(6'd0);
		send_frame(32'h7fffffff, 32'h80000000, 32'h00000000, 1'b0);
		send_frame(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0);
		send_frame(32'hffffffff, 32'h00000001, 32'h7fffffff, 1'b1);
		send_frame(32'h12345678, 32'hedcba987, 32'h80000000, 1'b1);
		// reset radius 50 but written, short sequence flushed at last
		set_radius(6'd50);
		send_frame(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
		send_frame(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
		send_frame(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
		send_frame(32'h00010000, 32'hffff0000, 32'h10000000, 1'b1);
		// small radius, sequence longer than the window
		set_radius(6'd2);
		run_sequence(12);

		// random phases; every phase ends on a last frame
		for (int ph = 0; words_sent < 370; ph++) begin
			r = ph < 8 ? radius_list[ph] : $urandom_range(0, 63);
			set_radius(6'(r));
			for (int s = 0; s < 3 && words_sent < 370; s++) begin
				if ($urandom_range(0, 5) == 0) len = $urandom_range(2 * r + 2, 2 * r + 10);
				else len = $urandom_range(1, 2 * r + 3 > 30 ? 30 : 2 * r + 3);
				if (r == 63 && s == 0) len = 130;
				run_sequence(len);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (results_owed != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("trajectory_moving_average_smoother_test OK");
		else
			$display("trajectory_moving_average_smoother_test NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("trajectory_moving_average_smoother_test NOT OK");
		$finish;
	end

endmodule
